@@ rtl/lcg_pkg.sv @@
package lcg_pkg;

    // Field widths fixed by the request format
    localparam int unsigned INC_FIELD_BITS = 31;
    localparam int unsigned LEN_FIELD_BITS = 16;
    localparam int unsigned AMP_BITS       = 15;
    localparam int unsigned SAMPLE_BITS    = 16;
    localparam int unsigned INC_BITS       = 32;   // increment as 0.32 fraction

    // Defaults for the top-level parameters
    localparam int unsigned PHASE_BITS_DEF = 32;
    localparam int unsigned TABLE_BITS_DEF = 10;
    localparam int unsigned LEN_BITS_DEF   = 16;

    // Sine table construction (Q30 Taylor series)
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned HALF_Q30    = 64'd536870912;
    localparam longint unsigned SINE_PEAK   = 64'd32767;

    localparam logic signed [31:0] ROUND_HALF = 32'sd16384;
    localparam logic signed [31:0] SAMPLE_MAX = 32'sd32767;
    localparam logic signed [31:0] SAMPLE_MIN = -32'sd32768;

    typedef struct packed {
        logic [INC_FIELD_BITS-1:0] start_inc;
        logic [INC_FIELD_BITS-1:0] end_inc;
        logic [LEN_FIELD_BITS-1:0] seg_len;
        logic [AMP_BITS-1:0]       amplitude;
        logic                      restart;
    } sweep_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          seg_last;
    } audio_t;

    // Quarter-wave entry k for a table of 2^tb entries, evaluated at (k + 0.5).
    // Elaboration time only.
    function automatic logic [AMP_BITS-1:0] sine_entry(input int unsigned k,
                                                       input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] t;
        logic [63:0] v;
        longint      acc;
        x    = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (tb + 1);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            t = (term * x2) >> 30;
            unique case (n)
                1:       term = t / 6;
                2:       term = t / 20;
                3:       term = t / 42;
                4:       term = t / 72;
                5:       term = t / 110;
                6:       term = t / 156;
                7:       term = t / 210;
                default: term = t / 272;
            endcase
            if ((n % 2) == 1) begin
                acc = acc - longint'(term);
            end
            else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (64'(acc) * SINE_PEAK + HALF_Q30) >> 30;
        if (v > SINE_PEAK) begin
            v = SINE_PEAK;
        end
        return v[AMP_BITS-1:0];
    endfunction

endpackage

@@ rtl/lcg_muldiv.sv @@
// Bit-serial floor(mag * mult / den): shift-add multiply, then restoring
// division one quotient bit per cycle. mult must be below den.
module lcg_muldiv #(
    parameter int unsigned LEN_BITS = lcg_pkg::LEN_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [lcg_pkg::INC_FIELD_BITS-1:0] mag,
    input  logic [LEN_BITS-1:0]                mult,
    input  logic [LEN_BITS-1:0]                den,
    output logic                               done,
    output logic [lcg_pkg::INC_FIELD_BITS-1:0] quot
);

    localparam int unsigned MAG_BITS = lcg_pkg::INC_FIELD_BITS;
    localparam int unsigned W        = MAG_BITS + LEN_BITS;
    localparam int unsigned CW       = $clog2(W + 1);

    logic                busy_reg,  busy_next;
    logic                div_reg,   div_next;     // 0: multiply pass, 1: divide pass
    logic                done_reg,  done_next;
    logic [CW-1:0]       cnt_reg,   cnt_next;
    logic [W-1:0]        acc_reg,   acc_next;     // product, then dividend/quotient
    logic [LEN_BITS-1:0] mult_reg,  mult_next;
    logic [LEN_BITS-1:0] rem_reg,   rem_next;
    logic [MAG_BITS-1:0] mag_reg;
    logic [LEN_BITS-1:0] den_reg;

    logic [LEN_BITS:0]   trial;
    logic                ge;

    assign trial = {rem_reg, acc_reg[W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mult_next = mult_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            div_next  = 1'b0;
            cnt_next  = CW'(LEN_BITS);
            acc_next  = '0;
            mult_next = mult;
            rem_next  = '0;
        end
        else if (busy_reg) begin
            cnt_next = cnt_reg - CW'(1);
            if (!div_reg) begin
                acc_next  = {acc_reg[W-2:0], 1'b0}
                          + (mult_reg[LEN_BITS-1] ? W'(mag_reg) : W'(0));
                mult_next = {mult_reg[LEN_BITS-2:0], 1'b0};
                if (cnt_reg == CW'(1)) begin
                    div_next = 1'b1;
                    cnt_next = CW'(W);
                end
            end
            else begin
                acc_next = {acc_reg[W-2:0], ge};
                rem_next = ge ? LEN_BITS'(trial - {1'b0, den_reg}) : trial[LEN_BITS-1:0];
                if (cnt_reg == CW'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg  <= acc_next;
        mult_reg <= mult_next;
        rem_reg  <= rem_next;
        if (start) begin
            mag_reg <= mag;
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = acc_reg[MAG_BITS-1:0];

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("muldiv started while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !div_reg)
        else $error("muldiv did not begin multiply pass");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && div_reg |-> rem_reg < den_reg)
        else $error("partial remainder reached divisor");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && quot <= mag_reg)
        else $error("quotient exceeds magnitude");

endmodule

@@ rtl/linear_chirp_generator.sv @@
// Linear chirp DDS sine generator.
// sweep channel (sweep_valid / sweep_stall / sweep): one request per audio
//   sample, carrying start and end increments, segment length, amplitude and
//   a restart flag that clears phase and sample index before this sample.
// audio channel (audio_valid / audio_stall / audio): one signed 16-bit sample
//   per request, with seg_last marking the final sample of a segment.
// One request is worked at a time. The interpolation floor(|end-start|*i/len)
//   runs on a bit-serial unit: LEN_BITS multiply steps, then 31 + LEN_BITS
//   divide steps. Once the divide finishes, the controller moves to ST_EMIT and
//   writes the sample to the output register as soon as that register is free;
//   no new request is taken before that write.
// The finished sample sits in an output register; a new request is taken
//   while it waits, and that request's sample is held back until the receiver
//   takes the earlier one. A stalled sample stays unchanged.
// Reset clears the phase accumulator, sample index and handshake state.
//   The sine table is a constant ROM and needs no fill.
module linear_chirp_generator #(
    parameter int unsigned PHASE_BITS = lcg_pkg::PHASE_BITS_DEF,
    parameter int unsigned TABLE_BITS = lcg_pkg::TABLE_BITS_DEF,
    parameter int unsigned LEN_BITS   = lcg_pkg::LEN_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sweep_valid,
    output logic            sweep_stall,
    input  lcg_pkg::sweep_t sweep,
    output logic            audio_valid,
    input  logic            audio_stall,
    output lcg_pkg::audio_t audio
);

    localparam int unsigned MAG_BITS   = lcg_pkg::INC_FIELD_BITS;
    localparam int unsigned AMP_BITS   = lcg_pkg::AMP_BITS;
    localparam int unsigned TABLE_SIZE = 2 ** TABLE_BITS;

    // Controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;   // serial multiply/divide running
    localparam logic [1:0] ST_EMIT = 2'd2;   // waiting for the output register

    // Quarter-wave sine ROM, built at elaboration
    typedef logic [AMP_BITS-1:0] rom_t [TABLE_SIZE];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            r[k] = lcg_pkg::sine_entry(k, TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [1:0]            state_reg, state_next;
    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [LEN_BITS-1:0]   sample_index_reg, sample_index_next;
    logic                  audio_valid_reg, audio_valid_next;
    lcg_pkg::audio_t       audio_reg, audio_next;

    // Per-request payload, loaded on accept
    logic [MAG_BITS-1:0]   start_reg;
    logic                  down_reg;       // end below start: frequency falls
    logic [AMP_BITS-1:0]   amp_reg;
    logic                  last_reg;
    logic [AMP_BITS-1:0]   rom_q_reg;
    logic                  sine_neg_reg;

    logic                  accept;
    logic                  emit;
    logic                  div_done;
    logic [MAG_BITS-1:0]   quot;

    // Accept-side decode
    logic [LEN_BITS-1:0]   len_raw;
    logic [LEN_BITS-1:0]   len_eff;
    logic [LEN_BITS-1:0]   idx_cur;
    logic [LEN_BITS-1:0]   idx_eff;
    logic                  is_last;
    logic                  down;
    logic [MAG_BITS-1:0]   mag;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [TABLE_BITS+1:0] phase_top;
    logic [TABLE_BITS-1:0] rom_addr;

    // Emit-side arithmetic
    logic [MAG_BITS-1:0]            inc31;
    logic [lcg_pkg::INC_BITS-1:0]   inc32;
    logic [PHASE_BITS-1:0]          inc_aligned;
    logic signed [AMP_BITS+1:0]     sine_s;
    logic signed [AMP_BITS:0]       amp_s;
    logic signed [31:0]             prod;
    logic signed [31:0]             scaled;
    logic signed [lcg_pkg::SAMPLE_BITS-1:0] sample_sat;

    assign accept      = sweep_valid && !sweep_stall;
    assign sweep_stall = (state_reg != ST_IDLE);
    assign emit        = (state_reg == ST_EMIT) && (!audio_valid_reg || !audio_stall);

    // Index handling: zero length counts as one; an index past the end
    // is clamped to the final sample.
    assign len_raw  = LEN_BITS'(sweep.seg_len);
    assign len_eff  = (len_raw == '0) ? LEN_BITS'(1) : len_raw;
    assign idx_cur  = sweep.restart ? '0 : sample_index_reg;
    assign idx_eff  = (idx_cur >= len_eff) ? len_eff - LEN_BITS'(1) : idx_cur;
    assign is_last  = (idx_eff == len_eff - LEN_BITS'(1));

    assign down = (sweep.end_inc < sweep.start_inc);
    assign mag  = down ? sweep.start_inc - sweep.end_inc : sweep.end_inc - sweep.start_inc;

    // Table lookup uses the phase before this sample's increment.
    // Odd quadrants read mirrored, the second half-cycle is negated.
    assign phase_cur = sweep.restart ? '0 : phase_acc_reg;
    assign phase_top = phase_cur[PHASE_BITS-1 -: TABLE_BITS+2];
    assign rom_addr  = phase_top[TABLE_BITS] ? ~phase_top[TABLE_BITS-1:0]
                                             : phase_top[TABLE_BITS-1:0];

    always_ff @(posedge clk) begin
        if (accept) begin
            rom_q_reg    <= SINE_ROM[rom_addr];
            sine_neg_reg <= phase_top[TABLE_BITS+1];
            start_reg    <= sweep.start_inc;
            down_reg     <= down;
            amp_reg      <= sweep.amplitude;
            last_reg     <= is_last;
        end
    end

    lcg_muldiv #(
        .LEN_BITS (LEN_BITS)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .mag   (mag),
        .mult  (idx_eff),
        .den   (len_eff),
        .done  (div_done),
        .quot  (quot)
    );

    // Interpolated increment, aligned to the accumulator width
    assign inc31 = down_reg ? start_reg - quot : start_reg + quot;
    assign inc32 = {1'b0, inc31};

    if (PHASE_BITS >= lcg_pkg::INC_BITS) begin : g_inc_wide
        assign inc_aligned = PHASE_BITS'(inc32) << (PHASE_BITS - lcg_pkg::INC_BITS);
    end
    else begin : g_inc_narrow
        assign inc_aligned = PHASE_BITS'(inc32 >> (lcg_pkg::INC_BITS - PHASE_BITS));
    end

    // amplitude * sine / 2^15, rounded down after adding one half, clamped
    assign sine_s = sine_neg_reg ? -$signed({2'b00, rom_q_reg}) : $signed({2'b00, rom_q_reg});
    assign amp_s  = $signed({1'b0, amp_reg});
    assign prod   = 32'(amp_s) * 32'(sine_s) + lcg_pkg::ROUND_HALF;
    assign scaled = prod >>> 15;

    always_comb begin
        priority if (scaled > lcg_pkg::SAMPLE_MAX) begin
            sample_sat = lcg_pkg::SAMPLE_BITS'(lcg_pkg::SAMPLE_MAX);
        end
        else if (scaled < lcg_pkg::SAMPLE_MIN) begin
            sample_sat = lcg_pkg::SAMPLE_BITS'(lcg_pkg::SAMPLE_MIN);
        end
        else begin
            sample_sat = lcg_pkg::SAMPLE_BITS'(scaled);
        end
    end

    always_comb begin
        state_next        = state_reg;
        phase_acc_next    = phase_acc_reg;
        sample_index_next = sample_index_reg;
        audio_valid_next  = audio_valid_reg;
        audio_next        = audio_reg;

        if (audio_valid_reg && !audio_stall) begin
            audio_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next        = ST_CALC;
                    phase_acc_next    = phase_cur;
                    sample_index_next = is_last ? '0 : idx_eff + LEN_BITS'(1);
                end
            end
            ST_CALC: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    state_next          = ST_IDLE;
                    phase_acc_next      = phase_acc_reg + inc_aligned;
                    audio_valid_next    = 1'b1;
                    audio_next.sample   = sample_sat;
                    audio_next.seg_last = last_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
            audio_valid_reg  <= 1'b0;
        end
        else begin
            state_reg        <= state_next;
            phase_acc_reg    <= phase_acc_next;
            sample_index_reg <= sample_index_next;
            audio_valid_reg  <= audio_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        audio_reg <= audio_next;
    end

    assign audio_valid = audio_valid_reg;
    assign audio       = audio_reg;

endmodule
